[design/pagg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagg_pkg: shared types and constants
// Sizes, status codes, controller states and the command/status bundles that
// join the preferential attachment controller to its datapath.
// ----------------------------------------------------------------------------
package pagg_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int MAX_EDGES    = 16;

  localparam int VTX_W   = $clog2(MAX_VERTICES);      // vertex index
  localparam int CNT_W   = VTX_W + 1;                 // vertex count
  localparam int LIST_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_W  = $clog2(MAX_EDGES) + 1;     // edge count
  localparam int IDX_W   = (CNT_W > EDGE_W) ? CNT_W : EDGE_W;
  localparam int FLD_W   = 13;                        // width of the final and initial config fields
  localparam int CMP_W   = (CNT_W > FLD_W) ? CNT_W : FLD_W;
  localparam int DEG_W   = 13;
  localparam int DEG_MAX = (1 << DEG_W) - 1;
  localparam int CUM_W   = DEG_W + VTX_W + 1;
  localparam int TOT_W   = 32;
  localparam int RND_W   = 32;
  localparam int PROD_W  = RND_W + TOT_W;
  localparam int SEEDP_W = CNT_W + DEG_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int EPV_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FINAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES   = 2'd2;

  localparam logic [FLD_W-1:0] RST_FINAL   = 13'd4096;
  localparam logic [FLD_W-1:0] RST_INITIAL = 13'd3;
  localparam logic [EPV_W-1:0] RST_EDGES   = 5'd2;

  typedef enum logic [1:0] {
    ST_EDGE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_START  = 2'd2,
    ST_FINISH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_MUL,
    S_WALK,
    S_CHECK,
    S_UPD_RD,
    S_UPD_WR,
    S_NEWV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    cap_draw;
    logic    start_init;
    logic    seed_wr;
    logic    mul;
    logic    walk;
    logic    append;
    logic    upd_rd;
    logic    upd_wr;
    logic    new_wr;
    logic    load_out;
    status_t out_status;
    logic    out_vdone;
  } dp_cmd_t;

  typedef struct packed {
    logic running;
    logic seed_last;
    logic walk_hit;
    logic dup;
    logic edge_more;
    logic upd_last;
    logic out_free;
  } dp_stat_t;

endpackage

[design/pagg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagg_ctrl: sequencing controller
// Walks a start through seeding, and a draw through threshold multiply,
// degree walk, duplicate check and degree update if due, to result hand-off.
// ----------------------------------------------------------------------------
module pagg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  input  pagg_pkg::dp_stat_t stat,
  output pagg_pkg::dp_cmd_t  cmd
);

  pagg_pkg::state_t  state_r, state_nxt;
  pagg_pkg::status_t st_r, st_nxt;
  logic              vd_r, vd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pagg_pkg::S_IDLE;
      st_r    <= pagg_pkg::ST_EDGE;
      vd_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      vd_r    <= vd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    vd_nxt    = vd_r;
    unique case (state_r)
      pagg_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (!in_action) begin
            state_nxt = pagg_pkg::S_SEED;
          end else if (!stat.running) begin
            st_nxt    = pagg_pkg::ST_FINISH;
            vd_nxt    = 1'b0;
            state_nxt = pagg_pkg::S_EMIT;
          end else begin
            state_nxt = pagg_pkg::S_MUL;
          end
        end
      end
      pagg_pkg::S_SEED: begin
        if (stat.seed_last) begin
          st_nxt    = pagg_pkg::ST_START;
          vd_nxt    = 1'b0;
          state_nxt = pagg_pkg::S_EMIT;
        end
      end
      pagg_pkg::S_MUL: begin
        state_nxt = pagg_pkg::S_WALK;
      end
      pagg_pkg::S_WALK: begin
        if (stat.walk_hit) begin
          state_nxt = pagg_pkg::S_CHECK;
        end
      end
      pagg_pkg::S_CHECK: begin
        priority if (stat.dup) begin
          st_nxt    = pagg_pkg::ST_DUP;
          vd_nxt    = 1'b0;
          state_nxt = pagg_pkg::S_EMIT;
        end else if (stat.edge_more) begin
          st_nxt    = pagg_pkg::ST_EDGE;
          vd_nxt    = 1'b0;
          state_nxt = pagg_pkg::S_EMIT;
        end else begin
          state_nxt = pagg_pkg::S_UPD_RD;
        end
      end
      pagg_pkg::S_UPD_RD: begin
        state_nxt = pagg_pkg::S_UPD_WR;
      end
      pagg_pkg::S_UPD_WR: begin
        state_nxt = stat.upd_last ? pagg_pkg::S_NEWV : pagg_pkg::S_UPD_RD;
      end
      pagg_pkg::S_NEWV: begin
        st_nxt    = pagg_pkg::ST_EDGE;
        vd_nxt    = 1'b1;
        state_nxt = pagg_pkg::S_EMIT;
      end
      pagg_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = pagg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pagg_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = st_r;
    cmd.out_vdone  = vd_r;
    in_ready       = 1'b0;
    unique case (state_r)
      pagg_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.start_init = in_valid & ~in_action;
        cmd.cap_draw   = in_valid & in_action;
      end
      pagg_pkg::S_SEED:   cmd.seed_wr  = 1'b1;
      pagg_pkg::S_MUL:    cmd.mul      = 1'b1;
      pagg_pkg::S_WALK:   cmd.walk     = 1'b1;
      pagg_pkg::S_CHECK:  cmd.append   = ~stat.dup;
      pagg_pkg::S_UPD_RD: cmd.upd_rd   = 1'b1;
      pagg_pkg::S_UPD_WR: cmd.upd_wr   = 1'b1;
      pagg_pkg::S_NEWV:   cmd.new_wr   = 1'b1;
      pagg_pkg::S_EMIT:   cmd.load_out = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[design/pagg_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagg_dp: attachment datapath
// Configuration registers, degree memory, cumulative-degree walk, list of
// vertices picked for the current new vertex, and the result register.
// ----------------------------------------------------------------------------
module pagg_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pagg_pkg::RND_W-1:0]          in_random_value,
  input  logic                                cfg_we,
  input  logic [pagg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pagg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  pagg_pkg::dp_cmd_t                   cmd,
  output pagg_pkg::dp_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [pagg_pkg::VTX_W-1:0]          out_new_vertex,
  output logic [pagg_pkg::VTX_W-1:0]          out_target_vertex,
  output logic                                out_vertex_done,
  output logic                                out_all_done
);

  // configuration
  logic [pagg_pkg::FLD_W-1:0] final_r, initial_r;
  logic [pagg_pkg::EPV_W-1:0] edges_r;

  // graph state
  logic [pagg_pkg::CNT_W-1:0]  n_r, m_r, cur_r;
  logic [pagg_pkg::EDGE_W-1:0] l_r, acc_r;
  logic [pagg_pkg::IDX_W-1:0]  cnt_r;
  logic [pagg_pkg::TOT_W-1:0]  total_r, hi_r;
  logic                        running_r;
  logic [pagg_pkg::RND_W-1:0]  rnd_r;
  logic [pagg_pkg::VTX_W-1:0]  list_r [pagg_pkg::MAX_EDGES];

  // walk
  logic [pagg_pkg::VTX_W-1:0]  addr_r, rd_idx_r, pick_r;
  logic                        rd_vld_r;
  logic [pagg_pkg::CUM_W-1:0]  cum_r;

  // degree memory
  logic [pagg_pkg::DEG_W-1:0]  deg_mem [pagg_pkg::MAX_VERTICES];
  logic [pagg_pkg::DEG_W-1:0]  rdata_r;

  // result register
  logic                        out_valid_r;
  pagg_pkg::status_t           out_status_r;
  logic [pagg_pkg::VTX_W-1:0]  out_nv_r, out_tv_r;
  logic                        out_vd_r, out_ad_r;

  // combinational
  logic [pagg_pkg::CMP_W-1:0]   cmp_max, cmp_final, cmp_init, cmp_edges, cmp_m, cmp_l0, cmp_l;
  logic [pagg_pkg::CMP_W-1:0]   cmp_deg;
  logic [pagg_pkg::CNT_W-1:0]   n_cl, m_cl;
  logic [pagg_pkg::EDGE_W-1:0]  l_cl;
  logic [pagg_pkg::DEG_W-1:0]   seed_deg;
  logic [pagg_pkg::SEEDP_W-1:0] seed_total;
  logic [pagg_pkg::PROD_W-1:0]  prod;
  logic [pagg_pkg::VTX_W-1:0]   list_rd, rd_addr, last_idx, wr_addr;
  logic [pagg_pkg::CUM_W-1:0]   sum;
  logic                         walk_hit, dup, deg_inc, mem_we;
  logic [pagg_pkg::DEG_W-1:0]   wr_data;

  always_comb begin
    cmp_max   = pagg_pkg::CMP_W'(pagg_pkg::MAX_VERTICES);
    cmp_final = pagg_pkg::CMP_W'(final_r);
    cmp_init  = pagg_pkg::CMP_W'(initial_r);
    cmp_edges = pagg_pkg::CMP_W'(edges_r);

    n_cl = pagg_pkg::CNT_W'((cmp_final > cmp_max) ? cmp_max : cmp_final);

    priority if (cmp_init > cmp_max) begin
      cmp_m = cmp_max;
    end else if (cmp_init < pagg_pkg::CMP_W'(2)) begin
      cmp_m = pagg_pkg::CMP_W'(2);
    end else begin
      cmp_m = cmp_init;
    end
    m_cl = pagg_pkg::CNT_W'(cmp_m);

    priority if (cmp_edges > pagg_pkg::CMP_W'(pagg_pkg::MAX_EDGES)) begin
      cmp_l0 = pagg_pkg::CMP_W'(pagg_pkg::MAX_EDGES);
    end else if (cmp_edges == '0) begin
      cmp_l0 = pagg_pkg::CMP_W'(1);
    end else begin
      cmp_l0 = cmp_edges;
    end
    cmp_l = (cmp_l0 > cmp_m) ? cmp_m : cmp_l0;
    l_cl  = pagg_pkg::EDGE_W'(cmp_l);

    // seed degree m-1, saturated to the degree width
    cmp_deg  = pagg_pkg::CMP_W'(m_r) - pagg_pkg::CMP_W'(1);
    seed_deg = (cmp_deg > pagg_pkg::CMP_W'(pagg_pkg::DEG_MAX)) ?
               pagg_pkg::DEG_W'(pagg_pkg::DEG_MAX) : pagg_pkg::DEG_W'(cmp_deg);
    seed_total = pagg_pkg::SEEDP_W'(m_r) * pagg_pkg::SEEDP_W'(seed_deg);

    prod = pagg_pkg::PROD_W'(rnd_r) * pagg_pkg::PROD_W'(total_r);

    list_rd = list_r[cnt_r[pagg_pkg::LIST_W-1:0]];
    rd_addr = cmd.upd_rd ? list_rd : addr_r;

    // cum << 32 > r * total reduces to cum > upper half of the product
    sum      = cum_r + pagg_pkg::CUM_W'(rdata_r);
    last_idx = pagg_pkg::VTX_W'(cur_r) - pagg_pkg::VTX_W'(1);
    walk_hit = rd_vld_r &&
               ((pagg_pkg::TOT_W'(sum) > hi_r) || (rd_idx_r == last_idx));

    dup = 1'b0;
    for (int i = 0; i < pagg_pkg::MAX_EDGES; i++) begin
      if ((pagg_pkg::EDGE_W'(i) < acc_r) && (list_r[i] == pick_r)) begin
        dup = 1'b1;
      end
    end

    deg_inc = (rdata_r < pagg_pkg::DEG_W'(pagg_pkg::DEG_MAX));

    mem_we = cmd.seed_wr | cmd.upd_wr | cmd.new_wr;
    priority if (cmd.seed_wr) begin
      wr_addr = cnt_r[pagg_pkg::VTX_W-1:0];
      wr_data = seed_deg;
    end else if (cmd.upd_wr) begin
      wr_addr = list_rd;
      wr_data = rdata_r + pagg_pkg::DEG_W'(deg_inc);
    end else begin
      wr_addr = cur_r[pagg_pkg::VTX_W-1:0];
      wr_data = pagg_pkg::DEG_W'(l_r);
    end
  end

  always_comb begin
    stat.running   = running_r;
    stat.seed_last = (cnt_r == pagg_pkg::IDX_W'(m_r) - pagg_pkg::IDX_W'(1));
    stat.walk_hit  = walk_hit;
    stat.dup       = dup;
    stat.edge_more = ((acc_r + pagg_pkg::EDGE_W'(1)) < l_r);
    stat.upd_last  = (cnt_r == pagg_pkg::IDX_W'(l_r) - pagg_pkg::IDX_W'(1));
    stat.out_free  = ~out_valid_r | out_ready;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      deg_mem[wr_addr] <= wr_data;
    end
    rdata_r <= deg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_r     <= pagg_pkg::RST_FINAL;
      initial_r   <= pagg_pkg::RST_INITIAL;
      edges_r     <= pagg_pkg::RST_EDGES;
      n_r         <= '0;
      m_r         <= '0;
      l_r         <= '0;
      cur_r       <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      running_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pagg_pkg::CFG_FINAL:   final_r   <= cfg_data;
          pagg_pkg::CFG_INITIAL: initial_r <= cfg_data;
          pagg_pkg::CFG_EDGES:   edges_r   <= cfg_data[pagg_pkg::EPV_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.start_init) begin
        n_r       <= n_cl;
        m_r       <= m_cl;
        l_r       <= l_cl;
        cur_r     <= m_cl;
        acc_r     <= '0;
        cnt_r     <= '0;
        running_r <= (m_cl < n_cl);
      end

      if (cmd.seed_wr) begin
        cnt_r   <= cnt_r + pagg_pkg::IDX_W'(1);
        total_r <= pagg_pkg::TOT_W'(seed_total);
      end

      // walk pipeline: each address is issued in the cycle before its data
      rd_vld_r <= cmd.walk;

      if (cmd.append) begin
        acc_r <= acc_r + pagg_pkg::EDGE_W'(1);
        cnt_r <= '0;
      end

      if (cmd.upd_wr) begin
        cnt_r   <= cnt_r + pagg_pkg::IDX_W'(1);
        total_r <= total_r + pagg_pkg::TOT_W'(deg_inc);
      end

      if (cmd.new_wr) begin
        total_r   <= total_r + pagg_pkg::TOT_W'(l_r);
        cur_r     <= cur_r + pagg_pkg::CNT_W'(1);
        acc_r     <= '0;
        running_r <= running_r & ((cur_r + pagg_pkg::CNT_W'(1)) < n_r);
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_draw) begin
      rnd_r <= in_random_value;
    end
    if (cmd.mul) begin
      hi_r   <= prod[pagg_pkg::PROD_W-1:pagg_pkg::TOT_W];
      addr_r <= '0;
      cum_r  <= '0;
    end
    if (cmd.walk) begin
      addr_r   <= addr_r + pagg_pkg::VTX_W'(1);
      rd_idx_r <= addr_r;
      if (walk_hit) begin
        pick_r <= rd_idx_r;
      end else if (rd_vld_r) begin
        cum_r <= sum;
      end
    end
    if (cmd.append) begin
      list_r[acc_r[pagg_pkg::LIST_W-1:0]] <= pick_r;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.out_status;
      // after a vertex completes, the index has already advanced
      out_nv_r     <= cmd.out_vdone ? last_idx : pagg_pkg::VTX_W'(cur_r);
      out_tv_r     <= ((cmd.out_status == pagg_pkg::ST_START) ||
                       (cmd.out_status == pagg_pkg::ST_FINISH)) ? '0 : pick_r;
      out_vd_r     <= cmd.out_vdone;
      out_ad_r     <= ~running_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_vertex    = out_nv_r;
  assign out_target_vertex = out_tv_r;
  assign out_vertex_done   = out_vd_r;
  assign out_all_done      = out_ad_r;

endmodule

[design/preferential_attachment_graph_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preferential_attachment_graph_gen: degree-proportional graph growth
// One transaction at a time: a start seeds the clique in the degree memory, a
// draw walks the cumulative degrees and reports the chosen edge.
// ----------------------------------------------------------------------------
// A start transaction writes the seed degrees one memory entry per cycle. A
// draw walks the degree memory up to the selected vertex, reading one entry
// per cycle through a single read port. A draw that completes a new vertex
// also does the read-modify-write of the l picked degrees and the write of
// the new vertex's degree. A draw before any start or after the final vertex
// returns a finish result without a walk. The next transaction is accepted
// as soon as the result sits in the output register.
module preferential_attachment_graph_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [pagg_pkg::RND_W-1:0]      in_random_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [pagg_pkg::VTX_W-1:0]      out_new_vertex,
  output logic [pagg_pkg::VTX_W-1:0]      out_target_vertex,
  output logic                            out_vertex_done,
  output logic                            out_all_done,
  input  logic                            cfg_we,
  input  logic [pagg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pagg_pkg::CFG_DATA_W-1:0] cfg_data
);

  pagg_pkg::dp_cmd_t  cmd;
  pagg_pkg::dp_stat_t stat;

  pagg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pagg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_random_value   (in_random_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_new_vertex    (out_new_vertex),
    .out_target_vertex (out_target_vertex),
    .out_vertex_done   (out_vertex_done),
    .out_all_done      (out_all_done)
  );

endmodule
